// ----- hdl/kse_pkg.sv -----
// shared types, constants and the key table for the keypad digit entry block
`default_nettype none

package kse_pkg;

	// width of the debounce down-counter
	localparam int DELAY_WIDTH = 16;

	// configuration register width and its reset value
	localparam int CFG_WIDTH = 16;
	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;

	// apb address width, register index sits above the byte offset
	localparam int ADDR_WIDTH = 3;
	localparam logic REG_DEBOUNCE = 1'b0;

	// key codes with a special meaning
	localparam logic [3:0] KEY_CLEAR = 4'd15;
	localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;

	// key cycle phases
	typedef enum logic [1:0] {
		PH_SCAN,
		PH_PRESS,
		PH_WAIT,
		PH_RELEASE
	} phase_t;

	// one result item
	typedef struct packed {
		logic [3:0] column_drive;
		logic [7:0] digits_low;
		logic [3:0] digits_high;
		logic       key_valid;
		logic [3:0] key_code;
	} result_t;

	// column/row to key code
	function automatic logic [3:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
		logic [3:0] code;
		begin
			code = 4'd0;
			case ({col, row})
				4'h0: code = 4'd13;
				4'h1: code = 4'd12;
				4'h2: code = 4'd11;
				4'h3: code = 4'd10;
				4'h4: code = 4'd14;
				4'h5: code = 4'd9;
				4'h6: code = 4'd6;
				4'h7: code = 4'd3;
				4'h8: code = 4'd0;
				4'h9: code = 4'd8;
				4'hA: code = 4'd5;
				4'hB: code = 4'd2;
				4'hC: code = 4'd15;
				4'hD: code = 4'd7;
				4'hE: code = 4'd4;
				4'hF: code = 4'd1;
				default: code = 4'd0;
			endcase
			return code;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/keypad_scan_digit_entry_top.sv -----
// Keypad scanner top level: one row sample is taken per transfer and
// yields exactly one result, so the block sustains one item per clock
// cycle while in_stall is low. All the work for a sample is a single
// pass through the scan and debounce logic in kse_core, which updates
// its state at the input transfer; the result goes into the output
// register, or into a one-entry skid buffer behind it while the output
// register holds an untaken result, so the input keeps flowing; in_stall
// rises only when both hold an untaken result. debounce_ticks is set
// through the apb port at byte address 0 and should only be written while no results are outstanding.
`default_nettype none

module keypad_scan_digit_entry_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// apb configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kse_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// row input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [3:0]                    row_sense,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [3:0]                         column_drive,
	output logic [7:0]                         digits_low,
	output logic [3:0]                         digits_high,
	output logic                               key_valid,
	output logic [3:0]                         key_code
);

	logic [kse_pkg::CFG_WIDTH-1:0] debounce_q;
	logic                          accept;
	logic                          full;
	logic                          reg_sel;
	kse_pkg::result_t              core_result;
	kse_pkg::result_t              out_data;

	// configuration register
	assign pready = 1'b1;
	assign reg_sel = paddr[kse_pkg::ADDR_WIDTH-1] == kse_pkg::REG_DEBOUNCE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kse_pkg::DEBOUNCE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			debounce_q <= pwdata[kse_pkg::CFG_WIDTH-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (reg_sel) begin
			prdata = {{(32-kse_pkg::CFG_WIDTH){1'b0}}, debounce_q};
		end
	end

	// input transfer
	assign in_stall = full;
	assign accept = in_valid && !full;

	kse_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.row_sense      (row_sense),
		.debounce_ticks (debounce_q),
		.result         (core_result)
	);

	kse_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (full)
	);

	// result fields
	assign column_drive = out_data.column_drive;
	assign digits_low = out_data.digits_low;
	assign digits_high = out_data.digits_high;
	assign key_valid = out_data.key_valid;
	assign key_code = out_data.key_code;

endmodule

`default_nettype wire

// ----- hdl/kse_core.sv -----
// scan, debounce and digit entry state with the per-tick result logic
`default_nettype none

module kse_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic [3:0]               row_sense,
	input  wire logic [kse_pkg::CFG_WIDTH-1:0] debounce_ticks,
	output kse_pkg::result_t              result
);

	kse_pkg::phase_t phase_q, phase_d;
	logic [1:0] col_q, col_d;
	logic [1:0] row_q, row_d;
	logic [kse_pkg::DELAY_WIDTH-1:0] cnt_q, cnt_d;
	logic [7:0] low_q, low_d;
	logic [3:0] high_q, high_d;
	logic [kse_pkg::DELAY_WIDTH-1:0] delay_load;
	logic       any_low;
	logic [1:0] first_low;
	logic       key_valid;
	logic [3:0] key_code;

	// delay reload value, truncated or zero-extended to the counter width
	generate
		if (kse_pkg::DELAY_WIDTH <= kse_pkg::CFG_WIDTH) begin : g_trunc
			assign delay_load = debounce_ticks[kse_pkg::DELAY_WIDTH-1:0];
		end else begin : g_ext
			assign delay_load = {{(kse_pkg::DELAY_WIDTH-kse_pkg::CFG_WIDTH){1'b0}},
				debounce_ticks};
		end
	endgenerate

	// lowest low row wins
	always_comb begin
		any_low = 1'b1;
		first_low = 2'd0;
		if (!row_sense[0]) begin
			first_low = 2'd0;
		end else if (!row_sense[1]) begin
			first_low = 2'd1;
		end else if (!row_sense[2]) begin
			first_low = 2'd2;
		end else if (!row_sense[3]) begin
			first_low = 2'd3;
		end else begin
			any_low = 1'b0;
		end
	end

	// next state and result
	always_comb begin
		phase_d = phase_q;
		col_d = col_q;
		row_d = row_q;
		cnt_d = cnt_q;
		low_d = low_q;
		high_d = high_q;
		key_valid = 1'b0;
		key_code = 4'd0;
		case (phase_q)
			kse_pkg::PH_SCAN: begin
				if (any_low) begin
					row_d = first_low;
					cnt_d = delay_load;
					phase_d = kse_pkg::PH_PRESS;
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			kse_pkg::PH_PRESS: begin
				if (cnt_q == '0) begin
					phase_d = kse_pkg::PH_WAIT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			kse_pkg::PH_WAIT: begin
				if (row_sense[row_q]) begin
					cnt_d = delay_load;
					phase_d = kse_pkg::PH_RELEASE;
				end
			end
			kse_pkg::PH_RELEASE: begin
				if (cnt_q == '0) begin
					key_valid = 1'b1;
					key_code = kse_pkg::key_lookup(col_q, row_q);
					phase_d = kse_pkg::PH_SCAN;
					col_d = 2'd0;
					if (key_code == kse_pkg::KEY_CLEAR) begin
						low_d = 8'd0;
						high_d = 4'd0;
					end else if (key_code <= kse_pkg::KEY_LAST_DIGIT) begin
						high_d = low_q[7:4];
						low_d = {low_q[3:0], key_code};
					end
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: begin
				phase_d = kse_pkg::PH_SCAN;
			end
		endcase
		result.column_drive = ~(4'b0001 << col_d);
		result.digits_low = low_d;
		result.digits_high = high_d;
		result.key_valid = key_valid;
		result.key_code = key_code;
	end

	// state register, advances once per accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kse_pkg::PH_SCAN;
			col_q <= 2'd0;
			row_q <= 2'd0;
			cnt_q <= '0;
			low_q <= 8'd0;
			high_q <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			col_q <= col_d;
			row_q <= row_d;
			cnt_q <= cnt_d;
			low_q <= low_d;
			high_q <= high_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/kse_out.sv -----
// result register with a one-entry skid buffer
`default_nettype none

module kse_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  kse_pkg::result_t       push_data,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output kse_pkg::result_t       out_data,
	output logic                   full
);

	logic             out_valid_q;
	kse_pkg::result_t out_q;
	logic             skid_valid_q;
	kse_pkg::result_t skid_q;
	logic             take;

	assign take = out_valid_q && !out_stall;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign full = skid_valid_q;

endmodule

`default_nettype wire

// ----- hdl/kse_checker.sv -----
// port-level checks for the keypad digit entry block, bound to the top level
`default_nettype none

module kse_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [3:0] column_drive,
	input wire logic [7:0] digits_low,
	input wire logic [3:0] digits_high,
	input wire logic       key_valid,
	input wire logic [3:0] key_code
);

	// exactly one column driven low
	a_one_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(column_drive) == 3)
		else $error("column_drive does not select a single column");

	// no key code without an accepted key
	a_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_code == 4'd0)
		else $error("key_code set without key_valid");

	// scanning restarts at column 0 once a key is accepted
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> column_drive == 4'b1110)
		else $error("scan did not restart at column 0");

	// clear key empties the display
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid && key_code == kse_pkg::KEY_CLEAR
		|-> digits_low == 8'd0 && digits_high == 4'd0)
		else $error("clear key left digits on the display");

	// a stalled transfer holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digits_low)
		&& $stable(digits_high) && $stable(key_code))
		else $error("stalled result changed");

endmodule

bind keypad_scan_digit_entry_top kse_checker u_kse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.column_drive (column_drive),
	.digits_low   (digits_low),
	.digits_high  (digits_high),
	.key_valid    (key_valid),
	.key_code     (key_code)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for the keypad scanner: emulated key presses checked against a tick-by-tick model
`timescale 1ns / 1ps

module tb_top;

	// key codes by column and row, nibble index = column*4 + row
	localparam logic [63:0] KEY_MAP = 64'h147F_2580_369E_ABCD;

	// tracks the scanner state and holds the results still due from the block
	class keypad_tracker;
		logic [15:0] debounce;
		logic [1:0] col;
		kse_pkg::phase_t ph;
		logic [1:0] held;
		logic [kse_pkg::DELAY_WIDTH-1:0] cnt;
		logic [7:0] shown_lo;
		logic [3:0] shown_hi;
		kse_pkg::result_t due_results[$];
		int fails;

		function new();
			debounce = kse_pkg::DEBOUNCE_RESET;
			col = 2'd0;
			ph = kse_pkg::PH_SCAN;
			held = 2'd0;
			cnt = '0;
			shown_lo = 8'd0;
			shown_hi = 4'd0;
			fails = 0;
		endfunction

		function void set_debounce(logic [15:0] value);
			debounce = value;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// one accepted row sample: advance the scan and work out the result
		function void note_rows(logic [3:0] rows);
			kse_pkg::result_t want;
			logic [3:0] code;
			logic hit;
			int r;
			int idx;
			code = 4'd0;
			hit = 1'b0;
			case (ph)
				kse_pkg::PH_SCAN: begin
					r = 0;
					while (r < 4 && rows[r])
						r++;
					if (r < 4) begin
						held = r[1:0];
						cnt = kse_pkg::DELAY_WIDTH'(debounce);
						ph = kse_pkg::PH_PRESS;
					end else begin
						col = col + 2'd1;
					end
				end
				kse_pkg::PH_PRESS: begin
					if (cnt == 0)
						ph = kse_pkg::PH_WAIT;
					else
						cnt = cnt - 1'b1;
				end
				kse_pkg::PH_WAIT: begin
					if (rows[held]) begin
						cnt = kse_pkg::DELAY_WIDTH'(debounce);
						ph = kse_pkg::PH_RELEASE;
					end
				end
				default: begin
					if (cnt == 0) begin
						idx = col * 4 + held;
						code = KEY_MAP[idx*4 +: 4];
						hit = 1'b1;
						// clear, shift in a digit, or leave the display alone
						if (code == kse_pkg::KEY_CLEAR) begin
							shown_lo = 8'd0;
							shown_hi = 4'd0;
						end else if (code <= kse_pkg::KEY_LAST_DIGIT) begin
							shown_hi = shown_lo[7:4];
							shown_lo = {shown_lo[3:0], code};
						end
						ph = kse_pkg::PH_SCAN;
						col = 2'd0;
					end else begin
						cnt = cnt - 1'b1;
					end
				end
			endcase
			want.column_drive = ~(4'b0001 << col);
			want.digits_low = shown_lo;
			want.digits_high = shown_hi;
			want.key_valid = hit;
			want.key_code = code;
			due_results.push_back(want);
		endfunction

		function void report(string field, logic [7:0] want, logic [7:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fails++;
		endfunction

		// compare a result transfer with the oldest one still due
		function void check_result(kse_pkg::result_t got);
			kse_pkg::result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				fails++;
				return;
			end
			want = due_results.pop_front();
			if (got.column_drive !== want.column_drive)
				report("column_drive", want.column_drive, got.column_drive);
			if (got.digits_low !== want.digits_low)
				report("digits_low", want.digits_low, got.digits_low);
			if (got.digits_high !== want.digits_high)
				report("digits_high", want.digits_high, got.digits_high);
			if (got.key_valid !== want.key_valid)
				report("key_valid", want.key_valid, got.key_valid);
			if (got.key_code !== want.key_code)
				report("key_code", want.key_code, got.key_code);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [kse_pkg::ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] row_sense = 4'hF;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] column_drive;
	logic [7:0] digits_low;
	logic [3:0] digits_high;
	logic key_valid;
	logic [3:0] key_code;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int items = 0;

	keypad_tracker trk = new();

	keypad_scan_digit_entry_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.row_sense(row_sense),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.column_drive(column_drive),
		.digits_low(digits_low),
		.digits_high(digits_high),
		.key_valid(key_valid),
		.key_code(key_code)
	);

	always #5 clk = ~clk;

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			trk.check_result({column_drive, digits_low, digits_high, key_valid, key_code});
		out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// one row sample transfer, with random idle cycles in front
	task automatic send_rows(input logic [3:0] rows);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		row_sense <= rows;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		trk.note_rows(rows);
		items++;
	endtask

	// stop offering and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (trk.pending() != 0)
			@(posedge clk);
	endtask

	// acts as a keypad with key (kc, kr) held, answering whichever column is driven;
	// rows the block ignores in the current phase carry random values
	task automatic press_key(input int kc, input int kr, input int hold);
		logic [3:0] rows;
		bit started;
		int waited;
		started = 0;
		waited = 0;
		while (!(started && trk.ph == kse_pkg::PH_SCAN)) begin
			rows = 4'($urandom);
			case (trk.ph)
				kse_pkg::PH_SCAN: begin
					if (trk.col == kc[1:0]) begin
						rows = rows | ((4'b0001 << kr) - 4'b0001);
						rows[kr] = 1'b0;
					end else begin
						rows = 4'hF;
					end
				end
				kse_pkg::PH_WAIT: begin
					rows[trk.held] = (waited >= hold);
					waited++;
				end
				default: ;
			endcase
			send_rows(rows);
			if (trk.ph != kse_pkg::PH_SCAN)
				started = 1;
		end
	endtask

	// apb setup and access phases; psel is left high for back-to-back use
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {kse_pkg::REG_DEBOUNCE, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
	endtask

	// write the debounce register and read it back
	task automatic program_debounce(input logic [15:0] value);
		logic [31:0] rd;
		apb_access(1'b1, {16'd0, value}, rd);
		trk.set_debounce(value);
		apb_access(1'b0, 32'd0, rd);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== {16'd0, value}) begin
			$display("%0t: debounce readback mismatch, expected %h, actual %h",
				$time, {16'd0, value}, rd);
			trk.fails++;
		end
	endtask

	// stimulus
	initial begin
		logic [31:0] rd;
		int target;
		int pick;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the debounce register
		apb_access(1'b0, 32'd0, rd);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== {16'd0, kse_pkg::DEBOUNCE_RESET}) begin
			$display("%0t: debounce reset mismatch, expected %h, actual %h",
				$time, {16'd0, kse_pkg::DEBOUNCE_RESET}, rd);
			trk.fails++;
		end

		// first tick after reset with two rows low, then all rows low
		send_rows(4'b0101);
		press_key(0, 1, 1);
		send_rows(4'h0);
		press_key(0, 0, 0);
		press_key(2, 2, 0);
		press_key(3, 0, 2);
		drain();

		// zero debounce: every key once
		program_debounce(16'd0);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				press_key(c, r, $urandom_range(0, 2));
		send_rows(4'hF);
		drain();

		// widest debounce value, written and read back only
		program_debounce(16'hFFFF);

		// random key entry under each idling pattern
		for (int mode = 0; mode < 4; mode++) begin
			program_debounce(16'($urandom_range(0, 4)));
			case (mode)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 88; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 88; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			if (mode == 0)
				hold_left <= 300;
			target = items + 200;
			while (items < target) begin
				if (mode == 2 && items >= target - 100 && items < target - 80)
					drain();
				pick = $urandom_range(99);
				if (pick < 85) begin
					press_key($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
				end else begin
					// bursts of arbitrary row noise
					n = $urandom_range(1, 6);
					repeat (n)
						send_rows(4'($urandom));
				end
			end
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;

		repeat (5) @(posedge clk);
		if (trk.fails == 0 && trk.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// run limit
	initial begin
		#500_000;
		$display("tb: failure");
		$finish;
	end

endmodule
